// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, switched off while reset is held.
`define SBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked property that also holds during reset.
`define SBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/sccbm_pkg.sv -----
// Types, constants and phase functions of the SCCB bit master.
`timescale 1ns / 1ps
package sccbm_pkg;

  localparam int BYTE_BITS = 8;
  localparam int BIT_W = 4;
  localparam int TICK_W = 16;
  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd100;

  // Bit index at which the data bits end and the acknowledge phases begin.
  localparam logic [BIT_W-1:0] BIT_DATA_END = BIT_W'(BYTE_BITS);
  localparam logic [BIT_W-1:0] BIT_WRITE_TAIL = BIT_W'(BYTE_BITS + 1);

  // Sub-phase codes within one three-phase bit slot.
  localparam logic [1:0] SUB_FIRST = 2'd0;
  localparam logic [1:0] SUB_SECOND = 2'd1;
  localparam logic [1:0] SUB_THIRD = 2'd2;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_NOACK = 3'd5
  } op_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
  } line_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy;
    logic                 done;
    logic                 ack_ok;
    logic [BYTE_BITS-1:0] read_data;
  } result_t;

  // Line changes made at the start of a phase, given as bit slot and sub-phase.
  function automatic line_t apply_phase(op_t op, logic [BIT_W-1:0] bit_idx,
                                        logic [1:0] sub, logic [BYTE_BITS-1:0] shift,
                                        line_t cur);
    line_t ln;
    ln = cur;
    case (op)
      OP_START: begin
        if (bit_idx != '0) begin
          ln.scl = 1'b0;
        end else if (sub == SUB_FIRST) begin
          ln.drive = 1'b1;
          ln.sda = 1'b1;
        end else if (sub == SUB_SECOND) begin
          ln.scl = 1'b1;
        end else begin
          ln.sda = 1'b0;
        end
      end
      OP_STOP: begin
        if (sub == SUB_FIRST) begin
          ln.drive = 1'b1;
          ln.sda = 1'b0;
        end else if (sub == SUB_SECOND) begin
          ln.scl = 1'b1;
        end else begin
          ln.sda = 1'b1;
        end
      end
      OP_NOACK: begin
        if (bit_idx != '0) begin
          ln.sda = 1'b0;
        end else if (sub == SUB_FIRST) begin
          ln.drive = 1'b1;
          ln.sda = 1'b1;
        end else if (sub == SUB_SECOND) begin
          ln.scl = 1'b1;
        end else begin
          ln.scl = 1'b0;
        end
      end
      OP_WRITE: begin
        if (bit_idx < BIT_DATA_END) begin
          if (sub == SUB_FIRST) begin
            ln.drive = 1'b1;
            ln.sda = shift[~bit_idx[2:0]];
          end else if (sub == SUB_SECOND) begin
            ln.scl = 1'b1;
          end else begin
            ln.scl = 1'b0;
          end
        end else if (bit_idx == BIT_DATA_END) begin
          // Release the line, then raise the clock for the acknowledge.
          if (sub == SUB_FIRST) begin
            ln.drive = 1'b0;
            ln.sda = 1'b1;
          end else if (sub == SUB_SECOND) begin
            ln.scl = 1'b1;
          end
        end else if (sub == SUB_FIRST) begin
          ln.scl = 1'b0;
        end
      end
      OP_READ: begin
        if (sub == SUB_FIRST) begin
          if (bit_idx == '0) begin
            ln.drive = 1'b0;
            ln.sda = 1'b1;
          end
          ln.scl = 1'b1;
        end else if (sub == SUB_THIRD) begin
          ln.scl = 1'b0;
        end
      end
      default: begin
        ln = cur;
      end
    endcase
    return ln;
  endfunction

  // True for the phase whose last tick samples the data line.
  function automatic logic phase_samples(op_t op, logic [BIT_W-1:0] bit_idx,
                                         logic [1:0] sub);
    logic s;
    case (op)
      OP_WRITE: s = (bit_idx == BIT_DATA_END) && (sub == SUB_SECOND);
      OP_READ:  s = (sub == SUB_FIRST);
      default:  s = 1'b0;
    endcase
    return s;
  endfunction

  // True once the phase position has moved past the last phase of the sequence.
  function automatic logic phase_over(op_t op, logic [BIT_W-1:0] bit_idx,
                                      logic [1:0] sub);
    logic e;
    case (op)
      OP_START, OP_NOACK: e = (bit_idx == BIT_W'(1)) && (sub == SUB_SECOND);
      OP_STOP:  e = (bit_idx == BIT_W'(1)) && (sub == SUB_FIRST);
      OP_WRITE: e = (bit_idx == BIT_WRITE_TAIL) && (sub == SUB_SECOND);
      OP_READ:  e = (bit_idx == BIT_DATA_END) && (sub == SUB_FIRST);
      default:  e = 1'b1;
    endcase
    return e;
  endfunction

endpackage

// ----- src/sccbm_core.sv -----
// Bus sequencer state and the per-tick update of the SCCB bit master.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sccbm_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  logic [2:0]                        cmd,
  input  logic [sccbm_pkg::BYTE_BITS-1:0]   wdat,
  input  logic                              sda,
  input  logic [sccbm_pkg::TICK_W-1:0]      phase_ticks,
  output sccbm_pkg::result_t                res
);

  sccbm_pkg::op_t                        op_r, op_nxt;
  logic [sccbm_pkg::BIT_W-1:0]           bit_r, bit_nxt;
  logic [1:0]                            sub_r, sub_nxt;
  logic [sccbm_pkg::TICK_W-1:0]          tick_r, tick_nxt, tick_inc;
  logic [sccbm_pkg::BYTE_BITS-1:0]       shift_r, shift_nxt;
  logic [sccbm_pkg::BYTE_BITS-1:0]       rd_r, rd_nxt;
  sccbm_pkg::line_t                      line_r, line_nxt;
  logic                                  ack_r, ack_nxt;
  logic                                  done_nxt;

  // One tick: take a command while idle, then count the tick and step the phase.
  always_comb begin
    op_nxt = op_r;
    bit_nxt = bit_r;
    sub_nxt = sub_r;
    tick_nxt = tick_r;
    shift_nxt = shift_r;
    rd_nxt = rd_r;
    line_nxt = line_r;
    ack_nxt = ack_r;
    done_nxt = 1'b0;
    tick_inc = '0;
    if ((op_r == sccbm_pkg::OP_IDLE) && (cmd >= sccbm_pkg::OP_START) &&
        (cmd <= sccbm_pkg::OP_NOACK)) begin
      op_nxt = sccbm_pkg::op_t'(cmd);
      bit_nxt = '0;
      sub_nxt = sccbm_pkg::SUB_FIRST;
      tick_nxt = '0;
      if (op_nxt == sccbm_pkg::OP_WRITE) begin
        shift_nxt = wdat;
      end else if (op_nxt == sccbm_pkg::OP_READ) begin
        shift_nxt = '0;
      end
      line_nxt = sccbm_pkg::apply_phase(op_nxt, bit_nxt, sub_nxt, shift_nxt, line_nxt);
    end
    if (op_nxt != sccbm_pkg::OP_IDLE) begin
      tick_inc = tick_nxt + sccbm_pkg::TICK_W'(1);
      if ((tick_inc >= phase_ticks) || (tick_inc == '0)) begin
        if (sccbm_pkg::phase_samples(op_nxt, bit_nxt, sub_nxt)) begin
          if (op_nxt == sccbm_pkg::OP_WRITE) begin
            ack_nxt = ~sda;
          end else begin
            shift_nxt = {shift_nxt[sccbm_pkg::BYTE_BITS-2:0], sda};
          end
        end
        if (sub_nxt == sccbm_pkg::SUB_THIRD) begin
          sub_nxt = sccbm_pkg::SUB_FIRST;
          bit_nxt = bit_nxt + sccbm_pkg::BIT_W'(1);
        end else begin
          sub_nxt = sub_nxt + 2'd1;
        end
        tick_nxt = '0;
        if (sccbm_pkg::phase_over(op_nxt, bit_nxt, sub_nxt)) begin
          // Byte transfers finish with the master driving the data line low.
          if ((op_nxt == sccbm_pkg::OP_WRITE) || (op_nxt == sccbm_pkg::OP_READ)) begin
            line_nxt.drive = 1'b1;
            line_nxt.sda = 1'b0;
          end
          if (op_nxt == sccbm_pkg::OP_READ) begin
            rd_nxt = shift_nxt;
          end
          op_nxt = sccbm_pkg::OP_IDLE;
          bit_nxt = '0;
          sub_nxt = sccbm_pkg::SUB_FIRST;
          done_nxt = 1'b1;
        end else begin
          line_nxt = sccbm_pkg::apply_phase(op_nxt, bit_nxt, sub_nxt, shift_nxt,
                                            line_nxt);
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end
  end

  // Result of this tick, taken from the updated state.
  always_comb begin
    res.scl_level = line_nxt.scl;
    res.sda_level = line_nxt.sda;
    res.sda_drive = line_nxt.drive;
    res.busy = (op_nxt != sccbm_pkg::OP_IDLE);
    res.done = done_nxt;
    res.ack_ok = ack_nxt;
    res.read_data = rd_nxt;
  end

  // State registers advance once per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= sccbm_pkg::OP_IDLE;
      bit_r <= '0;
      sub_r <= sccbm_pkg::SUB_FIRST;
      tick_r <= '0;
      shift_r <= '0;
      rd_r <= '0;
      line_r <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
      ack_r <= 1'b0;
    end else if (step_en) begin
      op_r <= op_nxt;
      bit_r <= bit_nxt;
      sub_r <= sub_nxt;
      tick_r <= tick_nxt;
      shift_r <= shift_nxt;
      rd_r <= rd_nxt;
      line_r <= line_nxt;
      ack_r <= ack_nxt;
    end
  end

  // An idle sequencer has a cleared phase position and tick count.
  `SBM_ASSERT(a_idle_clear, clk, rst_n, (op_r == sccbm_pkg::OP_IDLE) |-> ((tick_r == '0) && (bit_r == '0) && (sub_r == sccbm_pkg::SUB_FIRST)), "idle with live phase state")
  // The sub-phase counter never reaches its unused code.
  `SBM_ASSERT(a_sub_range, clk, rst_n, (sub_r != 2'd3), "sub-phase out of range")
  // A valid command seen while idle always starts a sequence.
  `SBM_ASSERT(a_cmd_starts, clk, rst_n, (step_en && (op_r == sccbm_pkg::OP_IDLE) && (cmd >= sccbm_pkg::OP_START) && (cmd <= sccbm_pkg::OP_NOACK)) |-> (res.busy || res.done), "command not taken")
  // Without a beat the sequencer state holds.
  `SBM_ASSERT(a_hold, clk, rst_n, !step_en |=> ($stable(op_r) && $stable(tick_r) && $stable(line_r)), "state moved without a beat")

endmodule

// ----- src/sccb_bit_master_top.sv -----
// Top level of the SCCB bit master: handshakes, configuration and pipeline registers.
`timescale 1ns / 1ps
// An accepted input beat passes the input register, then the sequencer update
// into the result register, before its result beat appears.
// Throughput: one beat per cycle while the result side takes every beat; the
// sequencer state update is a single pass between the two registers.
// Reset (rst_n, synchronous): sequencer idle, lines high and driven, ack and
// read byte cleared, phase_ticks back to 100, both pipeline stages empty.
module sccb_bit_master_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sccbm_pkg::TICK_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_command,
  input  logic [sccbm_pkg::BYTE_BITS-1:0]   in_write_data,
  input  logic                              in_sda_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_scl_level,
  output logic                              out_sda_level,
  output logic                              out_sda_drive,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic                              out_ack_ok,
  output logic [sccbm_pkg::BYTE_BITS-1:0]   out_read_data
);

  logic [sccbm_pkg::TICK_W-1:0]          phase_ticks_r;
  logic                                  s1_valid_r;
  logic [2:0]                            s1_cmd_r;
  logic [sccbm_pkg::BYTE_BITS-1:0]       s1_wdat_r;
  logic                                  s1_sda_r;
  logic                                  out_valid_r;
  sccbm_pkg::result_t                    out_res_r;
  sccbm_pkg::result_t                    step_res;
  logic                                  s2_ready;
  logic                                  step_en;

  // Pipeline flow control.
  assign s2_ready = !out_valid_r || out_ready;
  assign step_en = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= sccbm_pkg::PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= in_command;
      s1_wdat_r <= in_write_data;
      s1_sda_r <= in_sda_in;
    end
  end

  sccbm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .cmd         (s1_cmd_r),
    .wdat        (s1_wdat_r),
    .sda         (s1_sda_r),
    .phase_ticks (phase_ticks_r),
    .res         (step_res)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_scl_level = out_res_r.scl_level;
  assign out_sda_level = out_res_r.sda_level;
  assign out_sda_drive = out_res_r.sda_drive;
  assign out_busy_res = out_res_r.busy;
  assign out_done_res = out_res_r.done;
  assign out_ack_ok = out_res_r.ack_ok;
  assign out_read_data = out_res_r.read_data;

endmodule
